FILE: rtl/wpbe_pkg.sv
package wpbe_pkg;

   localparam int QueueDepth   = 2;
   localparam int BitsPerPixel = 24;
   localparam int ByteBits     = 8;
   localparam int NumSlots     = 3;
   localparam int IdxBits      = $clog2(BitsPerPixel);

   localparam logic [3:0] OneHigh  = 4'd8;
   localparam logic [3:0] OneLow   = 4'd4;
   localparam logic [3:0] ZeroHigh = 4'd4;
   localparam logic [3:0] ZeroLow  = 4'd8;

   localparam logic [IdxBits-1:0] LastIdx = IdxBits'(BitsPerPixel - 1);

   // register index, taken from paddr[3:2]
   localparam logic [1:0] RegBrightness = 2'd0;
   localparam logic [1:0] RegRedPos     = 2'd1;
   localparam logic [1:0] RegGreenPos   = 2'd2;
   localparam logic [1:0] RegBluePos    = 2'd3;

   localparam logic [7:0] BrightnessReset = 8'd255;
   localparam logic [1:0] RedPosReset     = 2'd1;
   localparam logic [1:0] GreenPosReset   = 2'd0;
   localparam logic [1:0] BluePosReset    = 2'd2;

   typedef struct packed {
      logic [7:0] brightness;
      logic [1:0] red_pos;
      logic [1:0] green_pos;
      logic [1:0] blue_pos;
   } cfg_type;

   typedef struct packed {
      logic [BitsPerPixel-1:0] bits;
      logic                    last;
   } word_type;

   // (c * b) / 255, exact for all 16-bit products
   function automatic logic [7:0] scale_channel(logic [7:0] c, logic [7:0] b);
      logic [15:0] prod;
      logic [16:0] sum;
      prod = c * b;
      sum  = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
      return sum[15:8];
   endfunction

endpackage

FILE: rtl/wpbe_front.sv
module wpbe_front (
   input  logic                          req_push,
   input  logic [23:0]                   req_pixel_color,
   input  logic                          req_last_pixel,
   input  wpbe_pkg::cfg_type             cfg,
   input  logic                          q_full,
   output logic                          q_push,
   output wpbe_pkg::word_type            q_data
);
   import wpbe_pkg::*;

   logic [7:0] red_s;
   logic [7:0] green_s;
   logic [7:0] blue_s;
   logic [ByteBits-1:0] slot [NumSlots];

   assign red_s   = scale_channel(req_pixel_color[23:16], cfg.brightness);
   assign green_s = scale_channel(req_pixel_color[15:8], cfg.brightness);
   assign blue_s  = scale_channel(req_pixel_color[7:0], cfg.brightness);

   // later channel wins on collision; position three lands nowhere
   always_comb begin
      for (int i = 0; i < NumSlots; i++) begin
         if (cfg.blue_pos == 2'(i)) begin
            slot[i] = blue_s;
         end else if (cfg.green_pos == 2'(i)) begin
            slot[i] = green_s;
         end else if (cfg.red_pos == 2'(i)) begin
            slot[i] = red_s;
         end else begin
            slot[i] = '0;
         end
      end
   end

   assign q_push      = req_push & ~q_full;
   assign q_data.bits = {slot[0], slot[1], slot[2]};
   assign q_data.last = req_last_pixel;

endmodule

FILE: rtl/wpbe_queue.sv
module wpbe_queue #(
   parameter int Depth = wpbe_pkg::QueueDepth
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  wpbe_pkg::word_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               valid,
   output wpbe_pkg::word_type pop_data
);
   import wpbe_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(Depth);

   word_type        mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full     = (count_ff == CntFull);
   assign valid    = (count_ff != '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/wpbe_back.sv
module wpbe_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  wpbe_pkg::word_type q_data,
   output logic               q_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [3:0]         rsp_high_ticks,
   output logic [3:0]         rsp_low_ticks,
   output logic               rsp_pixel_done,
   output logic               rsp_frame_done
);
   import wpbe_pkg::*;

   logic                    busy_ff, busy_in;
   logic [BitsPerPixel-1:0] word_ff, word_in;
   logic                    last_ff, last_in;
   logic [IdxBits-1:0]      idx_ff, idx_in;
   logic                    out_valid_ff, out_valid_in;
   logic [3:0]              high_ff, high_in;
   logic [3:0]              low_ff, low_in;
   logic                    pdone_ff, pdone_in;
   logic                    fdone_ff, fdone_in;
   logic                    advance;
   logic                    at_end;
   logic                    bit_now;

   assign advance = busy_ff & (~out_valid_ff | rsp_pop);
   assign at_end  = (idx_ff == LastIdx);
   assign q_pop   = q_valid & (~busy_ff | (advance & at_end));
   assign bit_now = word_ff[BitsPerPixel-1];

   always_comb begin
      busy_in      = busy_ff;
      word_in      = word_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      high_in      = high_ff;
      low_in       = low_ff;
      pdone_in     = pdone_ff;
      fdone_in     = fdone_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         high_in      = bit_now ? OneHigh : ZeroHigh;
         low_in       = bit_now ? OneLow : ZeroLow;
         pdone_in     = at_end;
         fdone_in     = at_end & last_ff;
         word_in      = {word_ff[BitsPerPixel-2:0], 1'b0};
         idx_in       = idx_ff + 1'b1;
         if (at_end) begin
            busy_in = 1'b0;
         end
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
      if (q_pop) begin
         busy_in = 1'b1;
         word_in = q_data.bits;
         last_in = q_data.last;
         idx_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      last_ff  <= last_in;
      idx_ff   <= idx_in;
      high_ff  <= high_in;
      low_ff   <= low_in;
      pdone_ff <= pdone_in;
      fdone_ff <= fdone_in;
   end

   assign rsp_empty      = ~out_valid_ff;
   assign rsp_high_ticks = high_ff;
   assign rsp_low_ticks  = low_ff;
   assign rsp_pixel_done = pdone_ff;
   assign rsp_frame_done = fdone_ff;

endmodule

FILE: rtl/ws2812_pixel_bit_encoder.sv
// An accepted item passes the queue and the serializer word register; its first symbol is then
// registered onto the rsp_ ports when the serializer is free.
// Throughput: 24 symbols per item, one per cycle while rsp_pop keeps the output drained.
// A small queue decouples pixel scaling from serialization.
// Reset (synchronous): queue and output empty, registers to brightness 255, positions 1/0/2.
module ws2812_pixel_bit_encoder #(
   parameter int QueueDepth = wpbe_pkg::QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [23:0] req_pixel_color,
   input  logic        req_last_pixel,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [3:0]  rsp_high_ticks,
   output logic [3:0]  rsp_low_ticks,
   output logic        rsp_pixel_done,
   output logic        rsp_frame_done,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import wpbe_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     cfg_we;
   logic     q_push;
   logic     q_pop;
   logic     q_valid;
   word_type q_wdata;
   word_type q_rdata;

   assign csr_pready = 1'b1;
   assign cfg_we     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_we) begin
         case (csr_paddr[3:2])
            RegBrightness: cfg_in.brightness = csr_pwdata[7:0];
            RegRedPos:     cfg_in.red_pos    = csr_pwdata[1:0];
            RegGreenPos:   cfg_in.green_pos  = csr_pwdata[1:0];
            RegBluePos:    cfg_in.blue_pos   = csr_pwdata[1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         RegBrightness: csr_prdata = {24'd0, cfg_ff.brightness};
         RegRedPos:     csr_prdata = {30'd0, cfg_ff.red_pos};
         RegGreenPos:   csr_prdata = {30'd0, cfg_ff.green_pos};
         RegBluePos:    csr_prdata = {30'd0, cfg_ff.blue_pos};
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.brightness <= BrightnessReset;
         cfg_ff.red_pos    <= RedPosReset;
         cfg_ff.green_pos  <= GreenPosReset;
         cfg_ff.blue_pos   <= BluePosReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   wpbe_front u_front (
      .req_push        (req_push),
      .req_pixel_color (req_pixel_color),
      .req_last_pixel  (req_last_pixel),
      .cfg             (cfg_ff),
      .q_full          (req_full),
      .q_push          (q_push),
      .q_data          (q_wdata)
   );

   wpbe_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (req_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_rdata)
   );

   wpbe_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_data         (q_rdata),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_high_ticks (rsp_high_ticks),
      .rsp_low_ticks  (rsp_low_ticks),
      .rsp_pixel_done (rsp_pixel_done),
      .rsp_frame_done (rsp_frame_done)
   );

endmodule

FILE: rtl/wpbe_checker.sv
module wpbe_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [3:0] rsp_high_ticks,
   input logic [3:0] rsp_low_ticks,
   input logic       rsp_pixel_done,
   input logic       rsp_frame_done
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("output not empty after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_high_ticks)
         && $stable(rsp_low_ticks) && $stable(rsp_pixel_done)
         && $stable(rsp_frame_done)))
      else $error("waiting item changed");

   a_period: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ((rsp_high_ticks == 4'd8 && rsp_low_ticks == 4'd4)
         || (rsp_high_ticks == 4'd4 && rsp_low_ticks == 4'd8)))
      else $error("bad symbol timing");

   a_frame_on_pixel: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_frame_done) |-> rsp_pixel_done)
      else $error("frame end without pixel end");

endmodule

bind ws2812_pixel_bit_encoder wpbe_checker u_wpbe_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_high_ticks (rsp_high_ticks),
   .rsp_low_ticks  (rsp_low_ticks),
   .rsp_pixel_done (rsp_pixel_done),
   .rsp_frame_done (rsp_frame_done)
);
